FILE: hdl/rgbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbf_pkg
// Shared types and constants of the RGB 3x3 neighbourhood filter.
// ----------------------------------------------------------------------------
package rgbf_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int QDEPTH        = 4;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [1:0] MODE_BOX = 2'd0;
	localparam logic [1:0] MODE_LAP = 2'd1;
	localparam logic [1:0] MODE_SHP = 2'd2;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	localparam logic [16:0] RECIP_1 = 17'd65536;
	localparam logic [16:0] RECIP_2 = 17'd32768;
	localparam logic [16:0] RECIP_3 = 17'd21846;
	localparam logic [16:0] RECIP_4 = 17'd16384;
	localparam logic [16:0] RECIP_6 = 17'd10923;
	localparam logic [16:0] RECIP_9 = 17'd7282;

	typedef struct packed {
		logic       operation;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic        emit;
		logic        row_top_ok;
		logic        row_bot_ok;
		logic        col_left_ok;
		logic        col_right_ok;
		logic        last;
		logic [23:0] top;
		logic [23:0] mid;
		logic [23:0] bot;
	} col_item_t;

endpackage

FILE: hdl/rgbf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbf_front
// Accepts pixels and flushes, keeps the raster counters and the line stores,
// and hands one window column per push to the queue.
// ----------------------------------------------------------------------------
module rgbf_front import rgbf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int WW = XW + 1,
	localparam int QCW = $clog2(QDEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  in_item_t        in_data,
	input  logic [WW-1:0]   w_eff,
	input  logic [12:0]     h_eff,
	input  logic [QCW-1:0]  q_count,
	output logic            q_push,
	output col_item_t       q_data
);

	localparam int CW = WW + 2;

	logic [XW-1:0] in_col_q, out_col_q, tmod_q;
	logic [11:0]   in_row_q, out_row_q;
	logic [CW-1:0] pend_q, tail_q;

	logic          acc, is_pix, flush_ok, push, emit;
	logic [CW-1:0] pend_a, tail_a;
	logic          in_col_end, in_row_end, out_col_end, out_row_end, frame_end, tmod_end;
	logic [XW-1:0] addr;

	logic          v_s1, pix_s1, emit_s1, top_s1, bot_s1, left_s1, right_s1, last_s1;
	logic [XW-1:0] addr_s1;
	logic [23:0]   data_s1;

	logic [47:0]   mem [MAX_WIDTH];
	logic [47:0]   rd_q, wr_data_q, cor;
	logic          wr_v_q, wr_en;
	logic [XW-1:0] wr_addr_q;

	assign in_stall = ((QCW+1)'(q_count) + (QCW+1)'(v_s1)) >= (QCW+1)'(QDEPTH);
	assign acc      = in_valid && !in_stall;
	assign is_pix   = in_data.operation == OP_PIXEL;
	assign flush_ok = !is_pix && pend_q != '0 && in_col_q == '0 && in_row_q == '0;
	assign push     = acc && (is_pix || flush_ok);
	assign pend_a   = pend_q + CW'(is_pix);
	assign tail_a   = tail_q + CW'(!is_pix);
	assign emit     = pend_a != '0 &&
		(({1'b0, pend_a} + {1'b0, tail_a}) >= ((CW+1)'(w_eff) + (CW+1)'(2)));

	assign in_col_end  = ({1'b0, in_col_q} + WW'(1)) >= w_eff;
	assign out_col_end = ({1'b0, out_col_q} + WW'(1)) >= w_eff;
	assign tmod_end    = ({1'b0, tmod_q} + WW'(1)) >= w_eff;
	assign in_row_end  = ({1'b0, in_row_q} + 13'd1) >= h_eff;
	assign out_row_end = ({1'b0, out_row_q} + 13'd1) >= h_eff;
	assign frame_end   = out_row_end && out_col_end;
	assign addr        = is_pix ? in_col_q : tmod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
			tail_q    <= '0;
			tmod_q    <= '0;
		end else if (push) begin
			if (is_pix) begin
				if (in_col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_end ? 12'd0 : in_row_q + 12'd1;
				end else begin
					in_col_q <= in_col_q + XW'(1);
				end
			end
			pend_q <= emit ? pend_a - CW'(1) : pend_a;
			if (emit && frame_end) begin
				tail_q <= '0;
				tmod_q <= '0;
			end else begin
				tail_q <= tail_a;
				if (!is_pix) begin
					tmod_q <= tmod_end ? '0 : tmod_q + XW'(1);
				end
			end
			if (emit) begin
				if (out_col_end) begin
					out_col_q <= '0;
					out_row_q <= out_row_end ? 12'd0 : out_row_q + 12'd1;
				end else begin
					out_col_q <= out_col_q + XW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			pix_s1 <= 1'b0;
			wr_v_q <= 1'b0;
		end else begin
			v_s1   <= push;
			pix_s1 <= push && is_pix;
			wr_v_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			addr_s1  <= addr;
			data_s1  <= is_pix ? {in_data.red_in, in_data.green_in, in_data.blue_in} : 24'd0;
			emit_s1  <= emit;
			top_s1   <= out_row_q != '0;
			bot_s1   <= !out_row_end;
			left_s1  <= out_col_q != '0;
			right_s1 <= !out_col_end;
			last_s1  <= frame_end;
		end
		wr_addr_q <= addr_s1;
		wr_data_q <= {cor[23:0], data_s1};
	end

	assign wr_en = v_s1 && pix_s1;

	always_ff @(posedge clk) begin
		if (push) begin
			rd_q <= mem[addr];
		end
		if (wr_en) begin
			mem[addr_s1] <= {cor[23:0], data_s1};
		end
	end

	assign cor = (wr_v_q && wr_addr_q == addr_s1) ? wr_data_q : rd_q;

	assign q_push = v_s1;
	always_comb begin
		q_data.emit         = emit_s1;
		q_data.row_top_ok   = top_s1;
		q_data.row_bot_ok   = bot_s1;
		q_data.col_left_ok  = left_s1;
		q_data.col_right_ok = right_s1;
		q_data.last         = last_s1;
		q_data.top          = cor[47:24];
		q_data.mid          = cor[23:0];
		q_data.bot          = data_s1;
	end

endmodule

FILE: hdl/rgbf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbf_queue
// Short FIFO of window columns between the front and the back.
// ----------------------------------------------------------------------------
module rgbf_queue import rgbf_pkg::*; #(
	localparam int QCW = $clog2(QDEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  col_item_t      push_data,
	input  logic           pop,
	output col_item_t      pop_data,
	output logic           nonempty,
	output logic [QCW-1:0] count
);

	localparam int QAW = $clog2(QDEPTH);

	col_item_t      ent_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QAW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QAW'(1);
			end
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	assign pop_data = ent_q[rp_q];
	assign nonempty = cnt_q != '0;
	assign count    = cnt_q;

endmodule

FILE: hdl/rgbf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbf_back
// Shifts columns into the 3x3 window and computes the filtered pixel.
// ----------------------------------------------------------------------------
module rgbf_back import rgbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] filter_mode,
	input  logic       q_valid,
	input  col_item_t  q_data,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data
);

	logic        adv;
	logic [23:0] win_q [9];
	logic        v_b1, top_b1, bot_b1, left_b1, right_b1, last_b1;

	logic [11:0] box_c [3];
	logic [11:0] kern_c [3];
	logic [16:0] recip_c;
	logic        is_kern;

	logic        v_b2, kern_b2, last_b2;
	logic [11:0] box_b2 [3];
	logic [11:0] kern_b2v [3];
	logic [16:0] recip_b2;

	logic        v_b3, kern_b3, last_b3;
	logic [28:0] prod_b3 [3];
	logic [7:0]  clamp_b3 [3];

	logic        out_v_q;
	out_item_t   out_q;

	assign adv   = !out_v_q || !out_stall;
	assign q_pop = adv && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
			v_b1    <= 1'b0;
			v_b2    <= 1'b0;
			v_b3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			if (q_valid) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= q_data.top;
				win_q[3] <= win_q[4];
				win_q[4] <= win_q[5];
				win_q[5] <= q_data.mid;
				win_q[6] <= win_q[7];
				win_q[7] <= win_q[8];
				win_q[8] <= q_data.bot;
			end
			v_b1    <= q_valid && q_data.emit;
			v_b2    <= v_b1;
			v_b3    <= v_b2;
			out_v_q <= v_b3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			top_b1   <= q_data.row_top_ok;
			bot_b1   <= q_data.row_bot_ok;
			left_b1  <= q_data.col_left_ok;
			right_b1 <= q_data.col_right_ok;
			last_b1  <= q_data.last;
		end
	end

	always_comb begin
		logic       rok [3];
		logic       cok [3];
		logic [7:0] v [9];
		logic [11:0] cross_sum;
		logic [1:0] nr, nc;
		logic [3:0] cnt;
		rok[0] = top_b1;
		rok[1] = 1'b1;
		rok[2] = bot_b1;
		cok[0] = left_b1;
		cok[1] = 1'b1;
		cok[2] = right_b1;
		is_kern = filter_mode == MODE_LAP || filter_mode == MODE_SHP;
		for (int ch = 0; ch < 3; ch++) begin
			box_c[ch] = '0;
			for (int i = 0; i < 9; i++) begin
				v[i] = (rok[i/3] && cok[i%3]) ? win_q[i][8*(2-ch) +: 8] : 8'd0;
				box_c[ch] = box_c[ch] + 12'(v[i]);
			end
			cross_sum = 12'(v[1]) + 12'(v[3]) + 12'(v[5]) + 12'(v[7]);
			if (filter_mode == MODE_LAP) begin
				kern_c[ch] = cross_sum - {2'b0, v[4], 2'b0};
			end else begin
				kern_c[ch] = {2'b0, v[4], 2'b0} + {4'b0, v[4]} - cross_sum;
			end
		end
		nr  = 2'd1 + 2'(top_b1) + 2'(bot_b1);
		nc  = 2'd1 + 2'(left_b1) + 2'(right_b1);
		cnt = 4'(nr) * 4'(nc);
		unique case (cnt)
			4'd2:    recip_c = RECIP_2;
			4'd3:    recip_c = RECIP_3;
			4'd4:    recip_c = RECIP_4;
			4'd6:    recip_c = RECIP_6;
			4'd9:    recip_c = RECIP_9;
			default: recip_c = RECIP_1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kern_b2  <= is_kern;
			last_b2  <= last_b1;
			recip_b2 <= recip_c;
			for (int ch = 0; ch < 3; ch++) begin
				box_b2[ch]   <= box_c[ch];
				kern_b2v[ch] <= kern_c[ch];
			end
			kern_b3 <= kern_b2;
			last_b3 <= last_b2;
			for (int ch = 0; ch < 3; ch++) begin
				prod_b3[ch] <= 29'(box_b2[ch]) * 29'(recip_b2);
				if (kern_b2v[ch][11]) begin
					clamp_b3[ch] <= 8'd0;
				end else if (kern_b2v[ch] > 12'd255) begin
					clamp_b3[ch] <= 8'd255;
				end else begin
					clamp_b3[ch] <= kern_b2v[ch][7:0];
				end
			end
			out_q.red_out    <= kern_b3 ? clamp_b3[0] : prod_b3[0][23:16];
			out_q.green_out  <= kern_b3 ? clamp_b3[1] : prod_b3[1][23:16];
			out_q.blue_out   <= kern_b3 ? clamp_b3[2] : prod_b3[2][23:16];
			out_q.frame_last <= last_b3;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

FILE: hdl/rgb_3x3_neighbourhood_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_3x3_neighbourhood_filter_core
// Streaming 3x3 box blur, laplacian and sharpen filter on RGB pixels.
// ----------------------------------------------------------------------------
// channel | signals                              | transaction when
// input   | in_valid, in_stall, in_data          | in_valid && !in_stall
// output  | out_valid, out_stall, out_data       | out_valid && !out_stall
// config  | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
// One pixel or flush per cycle while in_stall is low. The window lags the
// input by one row plus one pixel; a result then passes the front stage, the
// queue, and the back's window, b2, b3 and output registers.
// Reset clears counters, window and queue; line stores need no clearing.
// Output stall freezes the back; the queue then fills and raises in_stall.
// ----------------------------------------------------------------------------
module rgb_3x3_neighbourhood_filter_core import rgbf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int WW  = XW + 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	logic [1:0]     mode_q;
	logic [10:0]    width_q;
	logic [12:0]    height_q;
	logic [WW-1:0]  w_eff;
	logic [12:0]    h_eff;

	logic           q_push, q_pop, q_nonempty;
	col_item_t      q_wdata, q_rdata;
	logic [QCW-1:0] q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BOX;
			width_q  <= 11'd1024;
			height_q <= 13'd768;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[1:0];
				CFG_WIDTH:  width_q  <= cfg_data[10:0];
				CFG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (width_q == 11'd0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == 13'd0) begin
			h_eff = 13'd1;
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = 13'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	rgbf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.q_count (q_count),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	rgbf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.nonempty (q_nonempty),
		.count    (q_count)
	);

	rgbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.filter_mode(mode_q),
		.q_valid    (q_nonempty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

FILE: hdl/rgbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbf_checker
// Port-level checks on the filter core, bound to the top level.
// ----------------------------------------------------------------------------
module rgbf_checker import rgbf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data,
	input logic      cfg_valid,
	input logic      cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result shown during reset");

	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown(in_stall))
		else $error("input stall unknown");

endmodule

bind rgb_3x3_neighbourhood_filter_core rgbf_checker u_rgbf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
